/* design/dbrs_pkg.sv */
package dbrs_pkg;

   localparam int RANKS = 2;
   localparam int RANK_W = (RANKS > 1) ? $clog2(RANKS) : 1;
   localparam int SLOTS = 3;
   localparam int MASK_W = SLOTS * RANKS;
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [15:0] INTERVAL_RESET = 16'd3904;

   localparam logic CMD_PRECHARGE = 1'b0;
   localparam logic CMD_REFRESH = 1'b1;

   localparam logic [1:0] SLOT_PRE_FIRST = 2'd0;
   localparam logic [1:0] SLOT_PRE_SECOND = 2'd1;
   localparam logic [1:0] SLOT_REFRESH = 2'd2;

   localparam logic REG_INTERVAL = 1'b0;

   typedef struct packed {
      logic [47:0] now;
      logic [31:0] bank_open;
   } req_type;

   typedef struct packed {
      logic       command;
      logic       rank;
      logic [1:0] bank_group;
      logic [1:0] bank;
      logic [1:0] second_group;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [MASK_W-1:0]     mask;
      logic [RANKS-1:0][2:0] pair;
   } job_type;

   typedef struct packed {
      logic        write;
      logic [15:0] value;
      logic [15:0] interval;
   } cfg_type;

   function automatic logic bank_bit(input logic [31:0] open_bits, input int r,
                                     input logic [1:0] g, input logic [1:0] b);
      logic [5:0] idx;
      idx = 6'(r * 16) + {2'b00, g, b};
      return idx[5] ? 1'b0 : open_bits[idx[4:0]];
   endfunction

   function automatic logic [15:0] eff_interval(input logic [15:0] iv);
      return (iv == 16'd0) ? 16'd1 : iv;
   endfunction

endpackage

/* design/dbrs_front.sv */
module dbrs_front
   import dbrs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    q_full,
   output logic    q_push,
   output job_type q_job
);

   logic [RANKS-1:0][47:0] due_ff, due_in;
   logic [RANKS-1:0][2:0]  pair_ff, pair_in;
   logic [RANKS-1:0]       hit;
   logic [15:0]            iv;
   logic [15:0]            iv_new;
   logic                   accept;
   logic [1:0]             bnk;
   logic [1:0]             g1;

   assign req_stall = q_full;
   assign accept = req_valid && !req_stall;

   always_comb begin
      iv = eff_interval(cfg.interval);
      iv_new = eff_interval(cfg.value);
      due_in = due_ff;
      pair_in = pair_ff;
      q_job = '0;
      bnk = '0;
      g1 = '0;
      for (int r = 0; r < RANKS; r++) begin
         hit[r] = (req_data.now >= due_ff[r]);
         bnk = pair_ff[r][2:1];
         g1 = {pair_ff[r][0], 1'b0};
         q_job.pair[r] = pair_ff[r];
         q_job.mask[SLOTS*r] = hit[r] && bank_bit(req_data.bank_open, r, g1, bnk);
         q_job.mask[SLOTS*r+1] = hit[r] && bank_bit(req_data.bank_open, r, g1 | 2'b01, bnk);
         q_job.mask[SLOTS*r+2] = hit[r];
         if (cfg.write) begin
            due_in[r] = 48'(iv_new) * 48'(r + 1);
            pair_in[r] = 3'd0;
         end else if (accept && hit[r]) begin
            due_in[r] = due_ff[r] + 48'(iv);
            pair_in[r] = pair_ff[r] + 3'd1;
         end
      end
      q_push = accept && (|hit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < RANKS; r++) begin
            due_ff[r] <= 48'(INTERVAL_RESET) * 48'(r + 1);
            pair_ff[r] <= 3'd0;
         end
      end else begin
         due_ff <= due_in;
         pair_ff <= pair_in;
      end
   end

endmodule

/* design/dbrs_queue.sv */
module dbrs_queue
   import dbrs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   input  logic    pop,
   output job_type pop_data,
   output logic    full,
   output logic    empty
);

   job_type              mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   assign full = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign empty = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

/* design/dbrs_back.sv */
module dbrs_back
   import dbrs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  job_type q_job,
   input  logic    q_empty,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic                  cur_valid_ff, cur_valid_in;
   logic [MASK_W-1:0]     cur_mask_ff, cur_mask_in;
   logic [RANKS-1:0][2:0] cur_pair_ff, cur_pair_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  found;
   logic [RANK_W-1:0]     sel_r;
   logic [1:0]            sel_s;
   logic [MASK_W-1:0]     sel_bit;
   logic [MASK_W-1:0]     rem;
   logic [2:0]            pair;
   logic [1:0]            g1;
   logic                  out_free;
   logic                  emit;
   rsp_type               word;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      found = 1'b0;
      sel_r = '0;
      sel_s = SLOT_PRE_FIRST;
      sel_bit = '0;
      for (int r = 0; r < RANKS; r++) begin
         for (int s = 0; s < SLOTS; s++) begin
            if (!found && cur_mask_ff[SLOTS*r+s]) begin
               found = 1'b1;
               sel_r = RANK_W'(r);
               sel_s = 2'(s);
               sel_bit[SLOTS*r+s] = 1'b1;
            end
         end
      end
      rem = cur_mask_ff & ~sel_bit;
      pair = cur_pair_ff[sel_r];
      g1 = {pair[0], 1'b0};

      word.rank = sel_r[0];
      word.bank = pair[2:1];
      word.last = (rem == '0);
      unique case (sel_s)
         SLOT_PRE_FIRST: begin
            word.command = CMD_PRECHARGE;
            word.bank_group = g1;
            word.second_group = 2'd0;
         end
         SLOT_PRE_SECOND: begin
            word.command = CMD_PRECHARGE;
            word.bank_group = g1 | 2'b01;
            word.second_group = 2'd0;
         end
         SLOT_REFRESH: begin
            word.command = CMD_REFRESH;
            word.bank_group = g1;
            word.second_group = g1 | 2'b01;
         end
         default: begin
            word.command = CMD_REFRESH;
            word.bank_group = g1;
            word.second_group = g1 | 2'b01;
         end
      endcase

      out_free = !rsp_valid_ff || !rsp_stall;
      emit = cur_valid_ff && out_free;
      q_pop = !q_empty && (!cur_valid_ff || (emit && word.last));

      cur_valid_in = cur_valid_ff;
      cur_mask_in = cur_mask_ff;
      cur_pair_in = cur_pair_ff;
      if (q_pop) begin
         cur_valid_in = 1'b1;
         cur_mask_in = q_job.mask;
         cur_pair_in = q_job.pair;
      end else if (emit) begin
         cur_valid_in = !word.last;
         cur_mask_in = rem;
      end

      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_in = word;
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cur_mask_ff <= cur_mask_in;
      cur_pair_ff <= cur_pair_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* design/dual_bank_refresh_scheduler_unit.sv */
// A tick's words pass the queue, current-job and output registers. Ticks are taken one
// per cycle unless the queue is full; a due rank yields one to three words, one per
// cycle unless stalled, from a four-entry job queue that sets how far ticks may run
// ahead of output. Ticks with no due rank yield no word and never occupy the queue.
// Reset (synchronous): interval 3904, due times (rank+1)*interval, pair indexes 0,
// queue and output empty. An interval write restarts due times and pair indexes alike.
module dual_bank_refresh_scheduler_unit
   import dbrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [15:0] interval_ff, interval_in;
   cfg_type     cfg;
   logic        q_push;
   logic        q_pop;
   logic        q_full;
   logic        q_empty;
   job_type     push_job;
   job_type     pop_job;

   assign csr_pready = 1'b1;
   assign cfg.write = csr_psel && csr_penable && csr_pwrite && csr_pready
                      && (csr_paddr[2] == REG_INTERVAL);
   assign cfg.value = csr_pwdata[15:0];
   assign cfg.interval = interval_ff;
   assign interval_in = cfg.write ? cfg.value : interval_ff;
   assign csr_prdata = (csr_paddr[2] == REG_INTERVAL) ? {16'd0, interval_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
      end else begin
         interval_ff <= interval_in;
      end
   end

   dbrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   dbrs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_job),
      .pop       (q_pop),
      .pop_data  (pop_job),
      .full      (q_full),
      .empty     (q_empty)
   );

   dbrs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_job     (pop_job),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job pushed into full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("job popped from empty queue");

   a_precharge_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.command == CMD_PRECHARGE) |-> !rsp_data.last)
      else $error("precharge word marked last");

   a_refresh_groups: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.command == CMD_REFRESH) |->
         (!rsp_data.bank_group[0] && rsp_data.second_group == (rsp_data.bank_group | 2'b01)))
      else $error("refresh word with inconsistent bank groups");

endmodule

/* tb/dual_bank_refresh_scheduler_unit_test.sv */
`timescale 1ns / 100ps

module dual_bank_refresh_scheduler_unit_test;
   import dbrs_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [2:0] ADDR_INTERVAL = {REG_INTERVAL, 2'b00};
   localparam logic [2:0] ADDR_UNMAPPED = {~REG_INTERVAL, 2'b00};

   class refresh_scoreboard;
      logic [15:0] interval;
      logic [47:0] due_time [RANKS];
      logic [2:0]  pair_sel [RANKS];
      rsp_type     pending_words [$];
      int          errors;
      int          checked;

      function new();
         errors = 0;
         checked = 0;
         load_interval(INTERVAL_RESET);
      endfunction

      function logic [15:0] step_size();
         return (interval == 16'd0) ? 16'd1 : interval;
      endfunction

      function void load_interval(logic [15:0] value);
         interval = value;
         for (int r = 0; r < RANKS; r++) begin
            due_time[r] = 48'(r + 1) * 48'(step_size());
            pair_sel[r] = 3'd0;
         end
      endfunction

      function int note_tick(req_type t);
         rsp_type word;
         rsp_type held;
         logic [1:0] first_grp;
         logic [1:0] bnk;
         int idx;
         int n;
         n = 0;
         held = '0;
         for (int r = 0; r < RANKS; r++) begin
            if (t.now >= due_time[r]) begin
               due_time[r] = due_time[r] + 48'(step_size());
               bnk = pair_sel[r][2:1];
               first_grp = pair_sel[r][0] ? 2'd2 : 2'd0;
               for (int k = 0; k < 3; k++) begin
                  word = '0;
                  word.rank = r[0];
                  word.bank = bnk;
                  if (k < 2) begin
                     word.command = CMD_PRECHARGE;
                     word.bank_group = first_grp + 2'(k);
                     idx = r * 16 + int'(word.bank_group) * 4 + int'(bnk);
                     if (idx >= 32 || !t.bank_open[idx]) continue;
                  end else begin
                     word.command = CMD_REFRESH;
                     word.bank_group = first_grp;
                     word.second_group = first_grp + 2'd1;
                  end
                  if (n > 0) pending_words.push_back(held);
                  held = word;
                  n++;
               end
               pair_sel[r] = pair_sel[r] + 3'd1;
            end
         end
         if (n > 0) begin
            held.last = 1'b1;
            pending_words.push_back(held);
         end
         return n;
      endfunction

      function void check_word(rsp_type got);
         rsp_type want;
         if (pending_words.size() == 0) begin
            $error("unexpected word %h", got);
            errors++;
            return;
         end
         want = pending_words.pop_front();
         checked++;
         if (got.command !== want.command) begin
            $error("command: expected %0d, actual %0d", want.command, got.command);
            errors++;
         end
         if (got.rank !== want.rank) begin
            $error("rank: expected %0d, actual %0d", want.rank, got.rank);
            errors++;
         end
         if (got.bank_group !== want.bank_group) begin
            $error("bank_group: expected %0d, actual %0d", want.bank_group, got.bank_group);
            errors++;
         end
         if (got.bank !== want.bank) begin
            $error("bank: expected %0d, actual %0d", want.bank, got.bank);
            errors++;
         end
         if (got.second_group !== want.second_group) begin
            $error("second_group: expected %0d, actual %0d", want.second_group,
                   got.second_group);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   refresh_scoreboard sb = new();
   int  cycles = 0;
   int  csr_errors = 0;
   int  ticks_sent = 0;
   int  interval_writes = 0;
   int  stall_left = 0;
   bit  quiet = 1'b0;

   dual_bank_refresh_scheduler_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] pick_open();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return 32'h0;
      if (r == 1) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (!quiet && $urandom_range(0, 2) == 0) stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_word(rsp_data);
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[dual_bank_refresh_scheduler_unit] ERROR");
      $finish;
   end

   task automatic send_tick(input logic [47:0] now, input logic [31:0] open_bits,
                            output int made);
      req_type t;
      int gap;
      t.now = now;
      t.bank_open = open_bits;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (req_stall);
      made = sb.note_tick(t);
      ticks_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_INTERVAL) begin
         sb.load_interval(data[15:0]);
         interval_writes++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check(input logic [15:0] want);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= ADDR_INTERVAL;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[15:0] !== want) begin
         $error("refresh_interval: expected %0d, actual %0d", want, csr_prdata[15:0]);
         csr_errors++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input logic [15:0] iv, input int target);
      logic [47:0] count;
      logic [47:0] now;
      int step;
      int productive;
      int sent;
      int made;
      int r;
      settle();
      csr_write(ADDR_INTERVAL, {16'($urandom), iv});
      csr_check(iv);
      quiet = ($urandom_range(0, 3) == 0);
      step = (iv == 16'd0) ? 1 : int'(iv);
      count = '0;
      productive = 0;
      sent = 0;
      while (productive < target && sent < 36) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            now = {16'($urandom), 32'($urandom)};
         end else if (r < 12) begin
            now = count - 48'($urandom_range(0, step));
         end else begin
            count = count + 48'((r < 30) ? $urandom_range(0, 2 * step)
                                         : $urandom_range(0, step / 2 + 1));
            now = count;
         end
         send_tick(now, pick_open(), made);
         sent++;
         if (made > 0) productive++;
      end
   endtask

   initial begin
      int made;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check(INTERVAL_RESET);

      send_tick(48'd0, 32'hFFFF_FFFF, made);
      send_tick(48'd3903, 32'hFFFF_FFFF, made);
      send_tick(48'd3904, 32'hFFFF_FFFF, made);
      send_tick(48'd7808, 32'h0, made);
      send_tick(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, made);
      send_tick(48'hFFFF_FFFF_FFFF, 32'h0, made);
      send_tick(48'hFFFF_FFFF_FFFF, 32'h5555_5555, made);
      send_tick(48'hFFFF_FFFF_FFFF, 32'hAAAA_AAAA, made);
      send_tick(48'hFFFF_FFFF_FFFF, 32'h0000_FFFF, made);
      send_tick(48'hFFFF_FFFF_FFFF, 32'hFFFF_0000, made);
      send_tick(48'hFFFF_FFFF_FFFF, 32'h0F0F_F0F0, made);
      send_tick(48'hFFFF_FFFF_FFFF, $urandom, made);

      // zero interval runs as one
      settle();
      csr_write(ADDR_INTERVAL, 32'h0);
      csr_check(16'd0);
      send_tick(48'd0, 32'hFFFF_FFFF, made);
      send_tick(48'd1, 32'hFFFF_FFFF, made);
      send_tick(48'd1, 32'hFFFF_FFFF, made);
      send_tick(48'd2, 32'hFFFF_FFFF, made);

      settle();
      csr_write(ADDR_INTERVAL, 32'hFFFF_FFFF);
      csr_check(16'hFFFF);
      send_tick(48'd65534, 32'hFFFF_FFFF, made);
      send_tick(48'd65535, 32'hFFFF_FFFF, made);
      send_tick(48'h8000_0000_0000, 32'hFFFF_FFFF, made);

      // unmapped write must not restart the schedule
      settle();
      csr_write(ADDR_UNMAPPED, 32'h0000_0002);
      csr_check(16'hFFFF);
      send_tick(48'd2, 32'hFFFF_FFFF, made);

      settle();
      csr_write(ADDR_INTERVAL, 32'hABCD_0005);
      csr_check(16'd5);
      send_tick(48'd5, 32'hFFFF_FFFF, made);
      send_tick(48'd10, 32'hFFFF_FFFF, made);

      run_phase(16'd1, 35);
      run_phase(16'd0, 35);
      run_phase(16'hFFFF, 35);
      run_phase(16'($urandom_range(2, 40)), 35);
      run_phase(INTERVAL_RESET, 35);
      run_phase(16'($urandom_range(1, 65535)), 35);
      run_phase(16'($urandom_range(41, 999)), 35);
      run_phase(16'($urandom_range(2, 12)), 35);

      settle();
      repeat (10) @(posedge clock);
      $display("ran %0d ticks over %0d interval settings (0, 1, 3904, 65535 and random)",
               ticks_sent, interval_writes);
      $display("checked %0d command words, %0d left unmatched", sb.checked,
               sb.pending_words.size());
      if (sb.errors == 0 && csr_errors == 0 && sb.pending_words.size() == 0) begin
         $display("[dual_bank_refresh_scheduler_unit] OK");
      end else begin
         $display("[dual_bank_refresh_scheduler_unit] ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
design/dbrs_pkg.sv
design/dbrs_front.sv
design/dbrs_queue.sv
design/dbrs_back.sv
design/dual_bank_refresh_scheduler_unit.sv
tb/dual_bank_refresh_scheduler_unit_test.sv
